// ----- sv/i2cm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Command codes, same encoding as the kind field
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6
    } cmd_t;

    // Input item as seen on the s_ channel
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] wr_byte;
        logic       sda_in;
    } in_item_t;

    // Result item as seen on the m_ channel
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
    } out_item_t;

    // Classified item passed from front to back
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] wr_byte;
        logic       sda_in;
    } q_item_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int BITS_PER_BYTE = 8;

    // Register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_RESEND_ON_NACK = 1'b0;   // register index, paddr[2]
    localparam logic RESEND_RESET = 1'b1;

endpackage
`default_nettype wire

// ----- sv/i2c_master_bit_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine: one bus phase per tick item, APB control register.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one tick item per handshake (command kind, byte to write,
//   sampled SDA). m_ channel: exactly one result item per tick item (SCL and
//   SDA levels, busy, done, last read byte, last ack seen), in order.
//   APB port: register 0 (address 0) is resend_on_nack, bit 0, reset 1.
// Path: a tick passes the decode register, then a queue entry and the
//   engine output register before its result appears.
// Throughput: one item per clock unless the result channel stalls; the engine
//   applies one phase per accepted item, set by its single state update.
// Reset: aresetn low clears the engine to idle with both lines driven low,
//   empties the queue and sets resend_on_nack to 1.
// Stall: when m_ready is low the result holds in the output register; the
//   queue and decode register keep taking items until they fill, after
//   which s_ready drops.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core
    import i2cm_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic    resend_reg;
    logic    fq_valid;
    logic    fq_ready;
    q_item_t fq_item;
    logic    qe_valid;
    logic    qe_ready;
    q_item_t qe_item;

    // Register access
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resend_reg <= RESEND_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_RESEND_ON_NACK) begin
            resend_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RESEND_ON_NACK) begin
            prdata[0] = resend_reg;
        end
    end

    i2cm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_item  (fq_item)
    );

    i2cm_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qe_valid),
        .rd_ready (qe_ready),
        .rd_item  (qe_item)
    );

    i2cm_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .resend_on_nack (resend_reg),
        .q_valid        (qe_valid),
        .q_ready        (qe_ready),
        .q_item         (qe_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item)
    );

endmodule
`default_nettype wire

// ----- sv/i2cm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Input stage: takes tick items and decodes the kind field into a command.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          q_valid,
    input  wire logic     q_ready,
    output q_item_t       q_item
);

    logic    valid_reg;
    q_item_t item_reg;
    cmd_t    cmd_dec;

    // Kind decode; unused code behaves as tick only
    always_comb begin
        unique case (s_item.kind)
            CMD_START: cmd_dec = CMD_START;
            CMD_STOP:  cmd_dec = CMD_STOP;
            CMD_WRITE: cmd_dec = CMD_WRITE;
            CMD_READ:  cmd_dec = CMD_READ;
            CMD_ACK:   cmd_dec = CMD_ACK;
            CMD_NACK:  cmd_dec = CMD_NACK;
            default:   cmd_dec = CMD_IDLE;
        endcase
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    // Holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cmd     <= cmd_dec;
            item_reg.wr_byte <= s_item.wr_byte;
            item_reg.sda_in  <= s_item.sda_in;
        end
    end

endmodule
`default_nettype wire

// ----- sv/i2cm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_queue
// Small FIFO between the decode front and the line engine.
// ----------------------------------------------------------------------------
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    wr_valid,
    output logic         wr_ready,
    input  wire q_item_t wr_item,
    output logic         rd_valid,
    input  wire logic    rd_ready,
    output q_item_t      rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Fill level stays in range and tracks each push; no pop from an empty queue
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue over-filled");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count lost a push");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- sv/i2cm_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_engine
// Line engine: one bus phase per item, with the result output register.
// ----------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    resend_on_nack,
    input  wire logic    q_valid,
    output logic         q_ready,
    input  wire q_item_t q_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output out_item_t    m_item
);

    cmd_t       cmd_reg,   cmd_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] bc_reg,    bc_next;
    logic [7:0] sh_reg,    sh_next;
    logic       scl_reg,   scl_next;
    logic       sda_reg,   sda_next;
    logic       ack_reg,   ack_next;
    logic [7:0] rd_reg,    rd_next;
    logic       out_valid_reg;
    out_item_t  out_reg;

    cmd_t       cmd_cur;
    logic [1:0] phase_cur;
    logic [3:0] bc_cur;
    logic [7:0] sh_cur;
    logic       data_bit;
    logic       done;
    logic       adv;

    // Advance when an item waits and the output slot is free or draining
    assign adv     = q_valid && (!out_valid_reg || m_ready);
    assign q_ready = adv;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // Command launch, taken only while idle
    always_comb begin
        cmd_cur   = cmd_reg;
        phase_cur = phase_reg;
        bc_cur    = bc_reg;
        sh_cur    = sh_reg;
        if (cmd_reg == CMD_IDLE && q_item.cmd != CMD_IDLE) begin
            cmd_cur   = q_item.cmd;
            phase_cur = 2'd0;
            bc_cur    = 4'd0;
            if (q_item.cmd == CMD_WRITE) begin
                sh_cur = q_item.wr_byte;
            end else if (q_item.cmd == CMD_READ) begin
                sh_cur = 8'd0;
            end
        end
    end

    // Level driven in the data phase
    always_comb begin
        unique case (cmd_cur)
            CMD_STOP, CMD_ACK: data_bit = 1'b0;
            CMD_WRITE:         data_bit = bc_cur[3] ? 1'b1 : sh_cur[3'd7 - bc_cur[2:0]];
            default:           data_bit = 1'b1;
        endcase
    end

    // Phase step
    always_comb begin
        cmd_next   = cmd_cur;
        phase_next = phase_cur;
        bc_next    = bc_cur;
        sh_next    = sh_cur;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rd_next    = rd_reg;
        done       = 1'b0;
        if (cmd_cur != CMD_IDLE) begin
            case (phase_cur)
                2'd0: scl_next = 1'b0;
                2'd1: sda_next = data_bit;
                2'd2: scl_next = 1'b1;
                default: begin
                    unique case (cmd_cur)
                        CMD_START: begin
                            sda_next = 1'b0;
                            done     = 1'b1;
                        end
                        CMD_STOP: begin
                            sda_next = 1'b1;
                            done     = 1'b1;
                        end
                        CMD_WRITE: begin
                            if (!bc_cur[3]) begin
                                bc_next = bc_cur + 4'd1;
                            end else begin
                                // Acknowledge slot
                                ack_next = !q_item.sda_in;
                                if (q_item.sda_in && resend_on_nack) begin
                                    bc_next = 4'd0;
                                end else begin
                                    done = 1'b1;
                                end
                            end
                        end
                        CMD_READ: begin
                            sh_next = {sh_cur[6:0], q_item.sda_in};
                            bc_next = bc_cur + 4'd1;
                            if (bc_next >= 4'(BITS_PER_BYTE)) begin
                                rd_next = sh_next;
                                done    = 1'b1;
                            end
                        end
                        default: done = 1'b1;
                    endcase
                end
            endcase
            phase_next = phase_cur + 2'd1;
            if (done) begin
                cmd_next   = CMD_IDLE;
                phase_next = 2'd0;
            end
        end
    end

    // Engine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= 2'd0;
            bc_reg    <= 4'd0;
            sh_reg    <= 8'd0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
            ack_reg   <= 1'b0;
            rd_reg    <= 8'd0;
        end else if (adv) begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            sh_reg    <= sh_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rd_reg    <= rd_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.scl_out   <= scl_next;
            out_reg.sda_out   <= sda_next;
            out_reg.busy_res  <= (cmd_next != CMD_IDLE);
            out_reg.done_res  <= done;
            out_reg.read_byte <= rd_next;
            out_reg.ack_seen  <= ack_next;
        end
    end

    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg == CMD_IDLE) |-> (phase_reg == 2'd0))
        else $error("phase running while idle");
    a_bc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bc_reg <= 4'(BITS_PER_BYTE))
        else $error("bit count out of range");
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.done_res) |-> !out_reg.busy_res)
        else $error("done reported while still busy");
    a_read_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !done) |=> (rd_reg == $past(rd_reg)))
        else $error("read byte changed without a completed read");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master bit engine core.
// Tick items are fed from a queue through a valid/ready driver; every
// accepted tick runs through a bench-side line engine that predicts the
// SCL/SDA levels and status for that tick. A monitor compares each result
// item with the oldest prediction. Phases vary resend_on_nack over the APB
// port and the amount of idling on both channels; one phase holds the
// result channel off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import i2cm_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_TICKS = 8;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [APB_ADDR_W-1:0] RESEND_ADDR = APB_ADDR_W'(4 * REG_RESEND_ON_NACK);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    i2c_master_bit_engine_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Bench state
    in_item_t  tick_queue[$];   // ticks waiting to be offered
    out_item_t line_due[$];     // predicted results, oldest first
    int        fail_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_taken = 1'b0;
    int        hold_left = 0;

    // Bench copy of the line engine
    cmd_t       eng_cmd = CMD_IDLE;
    logic [1:0] eng_phase = '0;
    logic [3:0] eng_bits = '0;
    logic [7:0] eng_shift = '0;
    logic       eng_scl = 1'b0;
    logic       eng_sda = 1'b0;
    logic       eng_ack = 1'b0;
    logic [7:0] eng_rd = '0;
    logic       resend_cfg = RESEND_RESET;

    // Level SDA takes in phase 1 of the current slot
    function automatic logic slot_level();
        case (eng_cmd)
            CMD_START: return 1'b1;
            CMD_STOP:  return 1'b0;
            CMD_ACK:   return 1'b0;
            CMD_NACK:  return 1'b1;
            CMD_WRITE: return (eng_bits < 4'd8) ? eng_shift[7 - eng_bits] : 1'b1;
            default:   return 1'b1;
        endcase
    endfunction

    // Advance the engine by one tick and queue the result it produces
    task automatic engine_tick(input in_item_t it);
        logic      fin;
        out_item_t r;
        fin = 1'b0;
        if (eng_cmd == CMD_IDLE && it.kind >= CMD_START && it.kind <= CMD_NACK) begin
            eng_cmd   = cmd_t'(it.kind);
            eng_phase = '0;
            eng_bits  = '0;
            if (it.kind == CMD_WRITE)
                eng_shift = it.wr_byte;
            else if (it.kind == CMD_READ)
                eng_shift = '0;
        end
        if (eng_cmd != CMD_IDLE) begin
            case (eng_phase)
                2'd0: eng_scl = 1'b0;
                2'd1: eng_sda = slot_level();
                2'd2: eng_scl = 1'b1;
                default: begin
                    case (eng_cmd)
                        CMD_START: begin
                            eng_sda = 1'b0;
                            fin = 1'b1;
                        end
                        CMD_STOP: begin
                            eng_sda = 1'b1;
                            fin = 1'b1;
                        end
                        CMD_WRITE: begin
                            if (eng_bits < 4'd8) begin
                                eng_bits = eng_bits + 4'd1;
                            end else begin
                                eng_ack = (it.sda_in == 1'b0);
                                if (!eng_ack && resend_cfg)
                                    eng_bits = '0;
                                else
                                    fin = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            eng_shift = {eng_shift[6:0], it.sda_in};
                            eng_bits  = eng_bits + 4'd1;
                            if (eng_bits >= 4'd8) begin
                                eng_rd = eng_shift;
                                fin = 1'b1;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            endcase
            eng_phase = eng_phase + 2'd1;
            if (fin) begin
                eng_cmd   = CMD_IDLE;
                eng_phase = '0;
            end
        end
        r.scl_out   = eng_scl;
        r.sda_out   = eng_sda;
        r.busy_res  = (eng_cmd != CMD_IDLE);
        r.done_res  = fin;
        r.read_byte = eng_rd;
        r.ack_seen  = eng_ack;
        line_due.push_back(r);
    endtask

    // Input driver: offer queued ticks, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                engine_tick(s_item);
            if (!s_valid || s_ready) begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item  <= tick_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare with the oldest prediction, pick next ready
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (line_due.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, m_item);
                    fail_count++;
                end else begin
                    want = line_due.pop_front();
                    if (m_item.scl_out !== want.scl_out || m_item.sda_out !== want.sda_out ||
                        m_item.busy_res !== want.busy_res ||
                        m_item.done_res !== want.done_res ||
                        m_item.read_byte !== want.read_byte ||
                        m_item.ack_seen !== want.ack_seen) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, want, m_item);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // APB write followed by a read-back of the same register
    task automatic set_resend(input logic val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RESEND_ADDR;
        pwdata  <= APB_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        resend_cfg = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DATA_W'(val)) begin
            $display("%0t: register read expected %0h actual %0h", $realtime,
                     APB_DATA_W'(val), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic in_item_t mk_tick(input logic [2:0] k, input logic [7:0] b,
                                         input logic s);
        in_item_t it;
        it.kind    = k;
        it.wr_byte = b;
        it.sda_in  = s;
        return it;
    endfunction

    // Random command sequences: a command, then roughly enough plain ticks
    // to carry it through; some sequences cut short, some pure noise.
    task automatic queue_sequences(input int n);
        int         added;
        int         r;
        int         need;
        int         ack_bias;
        logic [2:0] k;
        logic [7:0] b;
        added = 0;
        while (added < n) begin
            r = $urandom_range(99);
            if (r < 8) begin
                tick_queue.push_back(mk_tick(3'($urandom_range(7)), 8'($urandom),
                                             1'($urandom)));
                added++;
            end else begin
                r = $urandom_range(99);
                if (r < 35)      k = CMD_WRITE;
                else if (r < 60) k = CMD_READ;
                else if (r < 75) k = CMD_START;
                else if (r < 85) k = CMD_STOP;
                else if (r < 93) k = CMD_ACK;
                else             k = CMD_NACK;
                r = $urandom_range(99);
                if (r < 10)      b = 8'h00;
                else if (r < 20) b = 8'hFF;
                else             b = 8'($urandom);
                tick_queue.push_back(mk_tick(k, b, 1'($urandom)));
                added++;
                if (k == CMD_WRITE)     need = 4 * (BITS_PER_BYTE + 1) - 1;
                else if (k == CMD_READ) need = 4 * BITS_PER_BYTE - 1;
                else                    need = 3;
                need = need + $urandom_range(2);
                if ($urandom_range(99) < 10)
                    need = $urandom_range(need);
                ack_bias = (k == CMD_WRITE) ? 70 : 50;
                repeat (need) begin
                    if ($urandom_range(99) < 10)
                        k = 3'($urandom_range(7));
                    else
                        k = CMD_IDLE;
                    tick_queue.push_back(mk_tick(k, 8'($urandom),
                                                 ($urandom_range(99) >= ack_bias)));
                    added++;
                end
            end
        end
    endtask

    // Wait until every tick is accepted and every result is back
    task automatic drain();
        do @(negedge aclk);
        while (tick_queue.size() != 0 || s_valid || line_due.size() != 0);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: unused kind, plain tick, each short command with commands
        // arriving while busy, every phase of start/stop/ack/nack
        tick_queue.push_back(mk_tick(3'd7, 8'hFF, 1'b1));
        tick_queue.push_back(mk_tick(CMD_IDLE, 8'h00, 1'b0));
        tick_queue.push_back(mk_tick(CMD_START, 8'h00, 1'b1));
        tick_queue.push_back(mk_tick(CMD_WRITE, 8'hFF, 1'b0));
        tick_queue.push_back(mk_tick(CMD_READ, 8'h55, 1'b1));
        tick_queue.push_back(mk_tick(CMD_STOP, 8'hAA, 1'b0));
        tick_queue.push_back(mk_tick(CMD_ACK, 8'h00, 1'b0));
        repeat (3) tick_queue.push_back(mk_tick(CMD_IDLE, 8'h00, 1'b1));
        tick_queue.push_back(mk_tick(CMD_NACK, 8'hFF, 1'b0));
        repeat (3) tick_queue.push_back(mk_tick(CMD_IDLE, 8'hFF, 1'b0));
        tick_queue.push_back(mk_tick(CMD_STOP, 8'h00, 1'b1));
        repeat (3) tick_queue.push_back(mk_tick(3'd7, 8'h00, 1'b1));
        drain();

        // No idling, resend on; long receiver hold-off to fill the pipe
        hold_req = 1'b1;
        queue_sequences(320);
        drain();

        // Resend off, sender idles
        set_resend(1'b0);
        @(negedge aclk);
        send_idle_pct  = 56;
        recv_stall_pct = 0;
        queue_sequences(320);
        drain();

        // Resend on, receiver stalls
        set_resend(1'b1);
        @(negedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        queue_sequences(320);
        drain();

        // Resend off, both sides idle
        set_resend(1'b0);
        @(negedge aclk);
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        queue_sequences(320);
        drain();

        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
